FILE: rtl/rtll_pkg.sv
package rtll_pkg;

  // number of route table slots
  localparam int ROUTE_SLOTS = 16;
  localparam int IDX_W       = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ROUTE_SLOTS + 1);

  localparam logic [31:0] STALE_LIMIT_RST = 32'd20;
  localparam logic [31:0] OWN_ADDRESS_RST = 32'd0;

  // register indexes on the configuration port
  localparam logic REG_STALE_LIMIT = 1'b0;
  localparam logic REG_OWN_ADDRESS = 1'b1;

  typedef struct packed {
    logic [31:0] stale_limit;
    logic [31:0] own_address;
  } cfg_t;

  // one route table entry as held in the slot memory
  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  port;
    logic [47:0] mac;
    logic [7:0]  hops;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic match;
    logic stale;
  } eval_t;

endpackage

FILE: rtl/rtll_ram.sv
module rtll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rtll_cfg.sv
module rtll_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rtll_pkg::cfg_t      cfg
);

  rtll_pkg::cfg_t cfg_r;
  rtll_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        rtll_pkg::REG_STALE_LIMIT: cfg_nxt.stale_limit = pwdata;
        rtll_pkg::REG_OWN_ADDRESS: cfg_nxt.own_address = pwdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rtll_pkg::REG_STALE_LIMIT: prdata = cfg_r.stale_limit;
      rtll_pkg::REG_OWN_ADDRESS: prdata = cfg_r.own_address;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stale_limit <= rtll_pkg::STALE_LIMIT_RST;
      cfg_r.own_address <= rtll_pkg::OWN_ADDRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/rtll_slot_eval.sv
module rtll_slot_eval (
  input  rtll_pkg::entry_t entry,
  input  logic             slot_valid,
  input  logic [31:0]      key,
  input  logic [31:0]      now,
  input  logic [31:0]      stale_limit,
  output rtll_pkg::eval_t  ev
);

  logic [31:0] age;

  // wrap-safe age
  assign age      = now - entry.stamp;
  assign ev.match = slot_valid && (entry.addr == key);
  assign ev.stale = (age >= stale_limit);

endmodule

FILE: rtl/route_table_learn_lookup_top.sv
// Reverse-route table with aging. Each input item is one received routing packet: the block
// first learns the route back to the item's source (an existing slot is updated only when
// forced, stale or offering no more hops; with no existing slot, take the lowest free slot,
// else the lowest stale slot, else flag learn_dropped), then looks up the destination and
// returns its port, next-hop MAC and hop count when the entry is fresh. The lookup sees the
// learning of the same item. All entries sit in one slot memory with a single read port,
// scanned one slot a cycle; the learning scan is skipped when the source equals own_address.
// The result sits in an output register, so a new item is taken while a finished result
// still waits. Slot valid bits are flip-flops cleared by reset, so no clearing pass is
// needed. The user must write configuration (stale_limit at 0x0, own_address at 0x4) only
// while the block is idle; the block itself does not enforce this.
module route_table_learn_lookup_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_source_addr,
  input  logic [7:0]  in_arrival_port,
  input  logic [47:0] in_neighbour_mac,
  input  logic [7:0]  in_learned_hops,
  input  logic        in_force_update,
  input  logic [31:0] in_lookup_addr,
  input  logic [31:0] in_now_seconds,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_route_changed,
  output logic        out_learn_dropped,
  output logic        out_route_hit,
  output logic [7:0]  out_port,
  output logic [47:0] out_next_mac,
  output logic [7:0]  out_route_hops,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N     = rtll_pkg::ROUTE_SLOTS;
  localparam int IDX_W = rtll_pkg::IDX_W;
  localparam int CNT_W = rtll_pkg::CNT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LEARN = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_LOOK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  rtll_pkg::cfg_t   cfg;
  rtll_pkg::entry_t rd_entry;
  rtll_pkg::entry_t wr_entry;
  rtll_pkg::eval_t  ev;

  state_t state_r, state_nxt;

  // scan control
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             scan_issue;

  // latched item
  logic [31:0] src_r, dst_r, now_r;
  logic [7:0]  port_r, hops_r;
  logic [47:0] mac_r;
  logic        force_r;

  // learning scan results
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic [7:0]       found_hops_r, found_hops_nxt;
  logic             found_stale_r, found_stale_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             stl_r, stl_nxt;
  logic [IDX_W-1:0] stl_idx_r, stl_idx_nxt;

  // per item result
  logic        changed_r, changed_nxt;
  logic        dropped_r, dropped_nxt;
  logic        lk_found_r, lk_found_nxt;
  logic        hit_r, hit_nxt;
  logic [7:0]  hport_r, hport_nxt;
  logic [47:0] hmac_r, hmac_nxt;
  logic [7:0]  hhops_r, hhops_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        o_changed_r, o_dropped_r, o_hit_r;
  logic [7:0]  o_port_r, o_hops_r;
  logic [47:0] o_mac_r;
  logic        out_load;

  logic [N-1:0]     valid_r;
  logic             ram_we;
  logic [IDX_W-1:0] wr_idx;
  logic             in_acc;
  logic [31:0]      key;

  rtll_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rtll_ram #(
    .WIDTH ($bits(rtll_pkg::entry_t)),
    .DEPTH (N)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_entry),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // key follows the phase: source while learning, destination while looking up
  assign key = (state_r == ST_LEARN) ? src_r : dst_r;

  rtll_slot_eval u_eval (
    .entry       (rd_entry),
    .slot_valid  (valid_r[rd_idx_r]),
    .key         (key),
    .now         (now_r),
    .stale_limit (cfg.stale_limit),
    .ev          (ev)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign scan_issue = (cnt_r < CNT_W'(N));
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign wr_entry.addr  = src_r;
  assign wr_entry.port  = port_r;
  assign wr_entry.mac   = mac_r;
  assign wr_entry.hops  = hops_r;
  assign wr_entry.stamp = now_r;

  // learning decision, taken in the write cycle
  always_comb begin
    ram_we      = 1'b0;
    wr_idx      = found_idx_r;
    changed_nxt = changed_r;
    dropped_nxt = dropped_r;
    if (state_r == ST_WRITE) begin
      priority if (found_r) begin
        if (force_r || found_stale_r || (hops_r <= found_hops_r)) begin
          ram_we      = 1'b1;
          changed_nxt = (hops_r != found_hops_r);
        end
      end else if (free_r) begin
        ram_we      = 1'b1;
        wr_idx      = free_idx_r;
        changed_nxt = 1'b1;
      end else if (stl_r) begin
        ram_we      = 1'b1;
        wr_idx      = stl_idx_r;
        changed_nxt = 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end else if (in_acc) begin
      changed_nxt = 1'b0;
      dropped_nxt = 1'b0;
    end
  end

  // sequencer and scans
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = cnt_r[IDX_W-1:0];
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_hops_nxt  = found_hops_r;
    found_stale_nxt = found_stale_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    stl_nxt         = stl_r;
    stl_idx_nxt     = stl_idx_r;
    lk_found_nxt    = lk_found_r;
    hit_nxt         = hit_r;
    hport_nxt       = hport_r;
    hmac_nxt        = hmac_r;
    hhops_nxt       = hhops_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          free_nxt     = 1'b0;
          stl_nxt      = 1'b0;
          lk_found_nxt = 1'b0;
          hit_nxt      = 1'b0;
          hport_nxt    = '0;
          hmac_nxt     = '0;
          hhops_nxt    = '0;
          // no learning for our own address
          state_nxt    = (in_source_addr == cfg.own_address) ? ST_LOOK : ST_LEARN;
        end
      end
      ST_LEARN: begin
        rd_vld_nxt = scan_issue;
        if (scan_issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_WRITE;
        end
        if (rd_vld_r) begin
          if (ev.match && !found_r) begin
            found_nxt       = 1'b1;
            found_idx_nxt   = rd_idx_r;
            found_hops_nxt  = rd_entry.hops;
            found_stale_nxt = ev.stale;
          end
          if (!valid_r[rd_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          // stale reuse only matters once every slot is valid
          if (valid_r[rd_idx_r] && ev.stale && !stl_r) begin
            stl_nxt     = 1'b1;
            stl_idx_nxt = rd_idx_r;
          end
        end
      end
      ST_WRITE: begin
        cnt_nxt   = '0;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        rd_vld_nxt = scan_issue;
        if (scan_issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
        if (rd_vld_r && ev.match && !lk_found_r) begin
          lk_found_nxt = 1'b1;
          if (!ev.stale) begin
            hit_nxt   = 1'b1;
            hport_nxt = rd_entry.port;
            hmac_nxt  = rd_entry.mac;
            hhops_nxt = rd_entry.hops;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register: holds while stalled, frees when taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r   <= in_source_addr;
      port_r  <= in_arrival_port;
      mac_r   <= in_neighbour_mac;
      hops_r  <= in_learned_hops;
      force_r <= in_force_update;
      dst_r   <= in_lookup_addr;
      now_r   <= in_now_seconds;
    end
    rd_idx_r      <= rd_idx_nxt;
    found_r       <= found_nxt;
    found_idx_r   <= found_idx_nxt;
    found_hops_r  <= found_hops_nxt;
    found_stale_r <= found_stale_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    stl_r         <= stl_nxt;
    stl_idx_r     <= stl_idx_nxt;
    changed_r     <= changed_nxt;
    dropped_r     <= dropped_nxt;
    lk_found_r    <= lk_found_nxt;
    hit_r         <= hit_nxt;
    hport_r       <= hport_nxt;
    hmac_r        <= hmac_nxt;
    hhops_r       <= hhops_nxt;
    if (out_load) begin
      o_changed_r <= changed_r;
      o_dropped_r <= dropped_r;
      o_hit_r     <= hit_r;
      o_port_r    <= hport_r;
      o_mac_r     <= hmac_r;
      o_hops_r    <= hhops_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_route_changed = o_changed_r;
  assign out_learn_dropped = o_dropped_r;
  assign out_route_hit     = o_hit_r;
  assign out_port          = o_port_r;
  assign out_next_mac      = o_mac_r;
  assign out_route_hops    = o_hops_r;

  // a learning step either changes a route or drops it, never both
  a_changed_xor_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_route_changed && out_learn_dropped))
    else $error("route changed and learning dropped on the same item");

  // a written slot is marked valid right after the write
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ram_we) |-> valid_r[$past(wr_idx)])
    else $error("slot written but not marked valid");

  // a lookup miss returns all-zero route fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_route_hit) |->
      (out_port == 8'd0 && out_next_mac == 48'd0 && out_route_hops == 8'd0))
    else $error("lookup miss with non-zero route fields");

  // the slot memory is only written between the two scans
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == ST_LOOK) && (cnt_r == '0))
    else $error("slot write outside the learning write cycle");

endmodule
